/* src/dlws_pkg.sv */
// Shared types and constants for the decayed-load worker selector.
`default_nettype none
package dlws_pkg;
  localparam int SLOT_COUNT   = 128;
  localparam int SLOT_W       = $clog2(SLOT_COUNT);
  localparam int SEARCH_WIDTH = 32;
  localparam int SEARCH_W     = $clog2(SEARCH_WIDTH + 1);
  localparam logic [SEARCH_W-1:0] SEARCH_FULL = SEARCH_W'(SEARCH_WIDTH);
  localparam int LOAD_W       = 10;

  localparam logic [31:0] SCAN_TAG   = 32'h5343_414E;
  localparam logic [31:0] SCAN_FLIP  = 32'h9e37_79b9;
  localparam logic [31:0] MIX_C1     = 32'h7feb_352d;
  localparam logic [31:0] MIX_C2     = 32'h846c_a68b;
  localparam logic [63:0] IDLE_NEVER = 64'h1000_0000_0000_0000;
  localparam logic [63:0] RECENT_SCAN_NS = 64'd2_000_000;
  // 1000 decay steps of 500 us: beyond this any load decays to zero
  localparam logic [63:0] DECAY_SAT_NS   = 64'd500_000_000;
  // diff/500000 = (diff>>5)/15625 = ((diff>>5) * RECIP) >> 38, exact below 2^24
  localparam logic [24:0] DECAY_RECIP = 25'd17592187;
  localparam int          DECAY_SHIFT = 38;
  localparam logic [LOAD_W-1:0] LOAD_CEIL   = 10'd1000;
  localparam logic [LOAD_W-1:0] SCAN_WEIGHT = 10'd6;
  localparam logic [LOAD_W-1:0] PLAIN_WEIGHT = 10'd1;

  typedef struct packed {
    logic [31:0] flow_hash;
    logic [31:0] random_word;
    logic [63:0] now_ns;
    logic [31:0] payload_word;
    logic        payload_has_four;
  } in_word_t;

  typedef struct packed {
    logic [6:0] chosen_slot;
    logic       by_policy;
  } out_word_t;

  typedef struct packed {
    logic [LOAD_W-1:0] load;
    logic [63:0]       touch;
    logic [63:0]       scan_stamp;
  } slot_rec_t;
endpackage
`default_nettype wire

/* src/decayed_load_worker_selector_unit.sv */
// Steps from accept to result: hash mixing in MIX1 and MIX2, a bit-serial hash mod active,
//   a scan of min(active, 32) slots, write back, out; straight to out with no active slot.
// Flow: one word at a time; the next word is taken the cycle after the result registers.
//   A result held by the receiver keeps the unit in its output state.
// Reset (rst, synchronous): active_workers 0, all slots read as unloaded via valid bits.
`default_nettype none
module decayed_load_worker_selector_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire dlws_pkg::in_word_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output dlws_pkg::out_word_t       out_data,
  input  wire logic                 cfg_we,
  input  wire logic [7:0]           cfg_wdata
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MIX1 = 3'd1;
  localparam logic [2:0] ST_MIX2 = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;
  localparam logic [2:0] ST_WB   = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  localparam int SW = dlws_pkg::SLOT_W;
  localparam int LW = dlws_pkg::LOAD_W;
  localparam logic [8:0] SLOT_LIMIT = 9'(dlws_pkg::SLOT_COUNT);

  logic [2:0] state;
  logic [7:0] active_workers;
  logic [7:0] act;
  logic [63:0] now;
  logic        scan;
  logic [31:0] h;
  logic [4:0]  bit_cnt;
  logic [7:0]  rem;
  logic [SW-1:0] addr;
  logic [SW-1:0] rd_slot;
  logic [SW-1:0] a_slot;
  logic [dlws_pkg::SEARCH_W-1:0] issued;
  logic [dlws_pkg::SEARCH_W-1:0] search;
  logic        rd_v, a_v, rd_live;
  logic [dlws_pkg::SLOT_COUNT-1:0] slot_valid;
  logic        policy;

  // stage A registers
  logic [48:0] a_prod;
  logic        a_big, a_live, a_recent;
  logic [LW-1:0] a_cur;
  logic [63:0] a_gap, a_scan;

  // running winner of the scan
  logic          found;
  logic [SW-1:0] win_slot;
  logic [LW:0]   win_cmp;
  logic [63:0]   win_gap;
  logic [LW-1:0] win_dl;
  logic [63:0]   win_scan;

  dlws_pkg::slot_rec_t rd_raw, rd_rec, wr_rec;
  logic        ram_we;

  dlws_ram #(.WIDTH($bits(dlws_pkg::slot_rec_t)), .DEPTH(dlws_pkg::SLOT_COUNT)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (win_slot),
    .wdata (wr_rec),
    .raddr (addr),
    .rdata (rd_raw)
  );

  assign in_ready = (state == ST_IDLE);

  // pre-mix hash from the incoming word
  logic        in_scan;
  logic [31:0] h_pre, h_x;
  logic [7:0]  act_in;
  always_comb begin
    in_scan = in_data.payload_has_four && (in_data.payload_word == dlws_pkg::SCAN_TAG);
    h_pre = (in_data.flow_hash == '0) ? in_data.random_word : in_data.flow_hash;
    if (in_scan) begin
      h_pre = h_pre ^ dlws_pkg::SCAN_FLIP;
    end
    h_pre = h_pre ^ in_data.now_ns[48:17];
    h_x = h_pre ^ (h_pre >> 16);
    act_in = ({1'b0, active_workers} > SLOT_LIMIT) ? 8'd0 : active_workers;
  end

  // second mixer round plus the final xor-shift
  logic [31:0] m1x, m2;
  assign m1x = h ^ (h >> 15);
  assign m2  = m1x * dlws_pkg::MIX_C2;

  // restoring divider step, one quotient bit per cycle
  logic [8:0] rem2;
  logic [7:0] rem_step;
  assign rem2 = {rem, h[31]};
  assign rem_step = (rem2 >= {1'b0, act}) ? 8'(rem2 - {1'b0, act}) : rem2[7:0];

  // stage A compute from the record read last cycle
  logic [63:0] diff, sdiff;
  logic        live, recent;
  always_comb begin
    rd_rec = rd_live ? rd_raw : '0;
    diff   = now - rd_rec.touch;
    live   = (rd_rec.touch != '0) && (now > rd_rec.touch);
    sdiff  = now - rd_rec.scan_stamp;
    recent = scan && (rd_rec.scan_stamp != '0) && (now > rd_rec.scan_stamp) &&
             (sdiff < dlws_pkg::RECENT_SCAN_NS);
  end

  // stage B: decayed load and compare
  logic [LW-1:0] q, b_dl;
  logic [LW:0]   b_cmp;
  logic          b_win;
  always_comb begin
    q = a_prod[dlws_pkg::DECAY_SHIFT +: LW];
    if (!a_live) begin
      b_dl = a_cur;
    end else if (a_big || q >= a_cur) begin
      b_dl = '0;
    end else begin
      b_dl = a_cur - q;
    end
    b_cmp = {1'b0, b_dl} + (a_recent ? 11'd2 : 11'd0);
    b_win = !found || (b_cmp < win_cmp) || ((b_cmp == win_cmp) && (a_gap > win_gap));
  end

  // write-back record
  logic [LW-1:0] w, new_load;
  always_comb begin
    w = scan ? dlws_pkg::SCAN_WEIGHT : dlws_pkg::PLAIN_WEIGHT;
    new_load = (win_dl >= dlws_pkg::LOAD_CEIL - w) ? dlws_pkg::LOAD_CEIL : win_dl + w;
    wr_rec.load = new_load;
    wr_rec.touch = now;
    wr_rec.scan_stamp = scan ? now : win_scan;
    ram_we = (state == ST_WB);
  end

  logic out_load;
  assign out_load = (state == ST_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      active_workers <= '0;
      out_valid <= 1'b0;
      slot_valid <= '0;
      rd_v <= 1'b0;
      a_v <= 1'b0;
      found <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_workers <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      rd_v <= (state == ST_SCAN) && (issued != search);
      a_v <= rd_v;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            now <= in_data.now_ns;
            scan <= in_scan;
            act <= act_in;
            h <= h_x;
            policy <= (act_in != '0);
            state <= (act_in == '0) ? ST_OUT : ST_MIX1;
          end
        end
        ST_MIX1: begin
          h <= h * dlws_pkg::MIX_C1;
          state <= ST_MIX2;
        end
        ST_MIX2: begin
          h <= m2 ^ (m2 >> 16);
          rem <= '0;
          bit_cnt <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          h <= {h[30:0], 1'b0};
          rem <= rem_step;
          bit_cnt <= bit_cnt + 5'd1;
          if (bit_cnt == 5'd31) begin
            // remainder is the ring start
            addr <= rem_step[SW-1:0];
            issued <= '0;
            search <= (act < 8'(dlws_pkg::SEARCH_WIDTH)) ? act[dlws_pkg::SEARCH_W-1:0]
                                                        : dlws_pkg::SEARCH_FULL;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issued != search) begin
            rd_slot <= addr;
            rd_live <= slot_valid[addr];
            issued <= issued + 1'b1;
            addr <= ({1'b0, addr} + 8'd1 == act) ? '0 : addr + 1'b1;
          end
          if (rd_v) begin
            a_slot <= rd_slot;
            a_prod <= 49'(diff[28:5]) * 49'(dlws_pkg::DECAY_RECIP);
            a_big <= diff >= dlws_pkg::DECAY_SAT_NS;
            a_live <= live;
            a_cur <= rd_rec.load;
            a_gap <= live ? diff : dlws_pkg::IDLE_NEVER;
            a_scan <= rd_rec.scan_stamp;
            a_recent <= recent;
          end
          if (a_v && b_win) begin
            found <= 1'b1;
            win_slot <= a_slot;
            win_cmp <= b_cmp;
            win_gap <= a_gap;
            win_dl <= b_dl;
            win_scan <= a_scan;
          end
          if (issued == search && !rd_v && !a_v) begin
            state <= ST_WB;
          end
        end
        ST_WB: begin
          slot_valid[win_slot] <= 1'b1;
          found <= 1'b0;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            out_data.chosen_slot <= policy ? 7'(win_slot) : 7'd0;
            out_data.by_policy <= policy;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

/* src/dlws_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dlws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/dlws_checker.sv */
// Port-level checks for the selector, bound to the top level.
`default_nettype none
module dlws_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire dlws_pkg::out_word_t out_data,
  input wire logic                out_valid,
  input wire logic                out_ready
);
  a_default_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.by_policy |-> out_data.chosen_slot == 7'd0)
    else $error("default result with nonzero slot");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("word taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");
endmodule

bind decayed_load_worker_selector_unit dlws_checker u_dlws_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_ready (out_ready)
);
`default_nettype wire
